/* hw/rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Operation codes of the input word, cursor update commands and the
// fixed byte values used for newline, blank cells and the reset attribute.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // operation field of the input word
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_BACK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // special character bytes
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] BLANK_BYTE   = 8'd32;

  // attribute register
  localparam logic [7:0] ATTR_RESET = 8'd15;
  localparam logic       REG_ATTR   = 1'b0;

  // cursor update commands
  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ADVANCE,
    CUR_NEWLINE,
    CUR_BACK,
    CUR_ROW_UP,
    CUR_HOME
  } cur_cmd_t;

endpackage

/* hw/rtl/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console
// Screen cells live in one single-port-write, registered-read memory.
// Clear, and a put that scrolls, each sweep the memory over all cells; the
// result word becomes valid as the writer returns to idle, ready for the
// next word, and one word is in flight at a time.
// Reset homes the cursor and loads attribute 15; screen cells stay undefined.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // operation[1:0], char_code[9:2], cell_index[20:10]
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cursor_cell[10:0], read_char[18:11],
                                  // read_attr[26:19], scrolled[27]
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int TOTAL = COLUMNS * ROWS;
  localparam int AW    = $clog2(TOTAL);
  localparam int CW    = $clog2(TOTAL + 1);
  localparam int KEEP  = TOTAL - COLUMNS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_CLEAR,
    S_RESP
  } state_t;

  state_t            st_r;
  logic [1:0]        op_r;
  logic [7:0]        ch_r;
  logic [10:0]       idx_r;
  logic [AW-1:0]     w_r;
  logic              scr_r;
  logic              use_rd_r;
  logic [7:0]        attr_r;

  logic              out_valid_r;
  logic [10:0]       out_cursor_r;
  logic [7:0]        out_char_r;
  logic [7:0]        out_attr_r;
  logic              out_scr_r;

  // screen store
  logic [15:0]       mem [TOTAL];
  logic [15:0]       rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  tcw_pkg::cur_cmd_t cmd;
  logic [CW-1:0]     cursor;
  logic [CW-1:0]     cursor_nxt;

  logic              out_free;
  logic              push;
  logic              push_rd;
  logic              at_end;
  logic              idx_ok;
  logic [15:0]       blank;
  logic              sweep_last;

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cursor     (cursor),
    .cursor_nxt (cursor_nxt)
  );

  assign out_free   = !out_valid_r || out_tready;
  assign at_end     = (cursor >= CW'(TOTAL));
  assign idx_ok     = ({21'd0, idx_r} < 32'(TOTAL));
  assign blank      = {attr_r, tcw_pkg::BLANK_BYTE};
  assign sweep_last = (w_r == AW'(TOTAL - 1));
  assign in_tready  = (st_r == S_IDLE);

  // drive memory ports, cursor command and result push
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    cmd       = tcw_pkg::CUR_HOLD;
    push      = 1'b0;
    push_rd   = 1'b0;
    case (st_r)
      S_EXEC: begin
        case (op_r)
          tcw_pkg::OP_PUT: begin
            if (at_end) begin
              // prime the scroll copy with the first cell of row one
              mem_re    = 1'b1;
              mem_raddr = AW'(COLUMNS);
            end else if (out_free) begin
              push = 1'b1;
              if (ch_r == tcw_pkg::NEWLINE_BYTE) begin
                cmd = tcw_pkg::CUR_NEWLINE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cursor);
                mem_wdata = {attr_r, ch_r};
                cmd       = tcw_pkg::CUR_ADVANCE;
              end
            end
          end
          tcw_pkg::OP_BACK: begin
            if (out_free) begin
              push = 1'b1;
              if (cursor != '0) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cursor - CW'(1));
                mem_wdata = blank;
                cmd       = tcw_pkg::CUR_BACK;
              end
            end
          end
          tcw_pkg::OP_READ: begin
            if (idx_ok) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(idx_r);
            end
          end
          default: begin
            mem_we = 1'b0;
          end
        endcase
      end
      S_SCROLL: begin
        // write one cell up a row, or a blank in the last row, while fetching the next one
        mem_we    = 1'b1;
        mem_waddr = w_r;
        mem_wdata = (w_r < AW'(KEEP)) ? rd_data_r : blank;
        if (w_r < AW'(KEEP - 1)) begin
          mem_re    = 1'b1;
          mem_raddr = w_r + AW'(COLUMNS + 1);
        end
        if (sweep_last) begin
          cmd = tcw_pkg::CUR_ROW_UP;
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = w_r;
        mem_wdata = blank;
        if (sweep_last) begin
          cmd = tcw_pkg::CUR_HOME;
        end
      end
      S_RESP: begin
        push    = out_free;
        push_rd = use_rd_r;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // sequence operations and hold the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      scr_r       <= 1'b0;
      use_rd_r    <= 1'b0;
      w_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r  <= in_tdata[1:0];
            ch_r  <= in_tdata[9:2];
            idx_r <= in_tdata[20:10];
            scr_r <= 1'b0;
            st_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op_r)
            tcw_pkg::OP_PUT: begin
              if (at_end) begin
                w_r  <= '0;
                st_r <= S_SCROLL;
              end else if (out_free) begin
                st_r <= S_IDLE;
              end
            end
            tcw_pkg::OP_BACK: begin
              if (out_free) begin
                st_r <= S_IDLE;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              w_r  <= '0;
              st_r <= S_CLEAR;
            end
            default: begin
              use_rd_r <= idx_ok;
              st_r     <= S_RESP;
            end
          endcase
        end
        S_SCROLL: begin
          w_r <= w_r + AW'(1);
          if (sweep_last) begin
            scr_r <= 1'b1;
            st_r  <= S_EXEC;
          end
        end
        S_CLEAR: begin
          w_r <= w_r + AW'(1);
          if (sweep_last) begin
            use_rd_r <= 1'b0;
            st_r     <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            st_r <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase

      // load or drain the result register
      if (push) begin
        out_valid_r  <= 1'b1;
        out_cursor_r <= 11'(cursor_nxt);
        out_char_r   <= push_rd ? rd_data_r[7:0] : 8'd0;
        out_attr_r   <= push_rd ? rd_data_r[15:8] : 8'd0;
        out_scr_r    <= scr_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // screen memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcw_pkg::ATTR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == tcw_pkg::REG_ATTR)) begin
      attr_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == tcw_pkg::REG_ATTR) ? {24'd0, attr_r} : 32'd0;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_scr_r, out_attr_r, out_char_r, out_cursor_r};

endmodule

/* hw/rtl/tcw_cursor.sv */
// ----------------------------------------------------------------------------
// tcw_cursor: cursor position unit
// Holds the cursor in cells together with its column, so that newline,
// advance, backspace and scroll updates need only adds and compares.
// ----------------------------------------------------------------------------
module tcw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tcw_pkg::cur_cmd_t                      cmd,
  output logic [$clog2(COLUMNS*ROWS+1)-1:0]      cursor,
  output logic [$clog2(COLUMNS*ROWS+1)-1:0]      cursor_nxt
);

  localparam int CW   = $clog2(COLUMNS*ROWS+1);
  localparam int COLW = $clog2(COLUMNS);

  logic [CW-1:0]   cursor_r;
  logic [COLW-1:0] col_r;
  logic [COLW-1:0] col_nxt;

  // compute the next position
  always_comb begin
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    case (cmd)
      tcw_pkg::CUR_ADVANCE: begin
        cursor_nxt = cursor_r + CW'(1);
        col_nxt    = (col_r == COLW'(COLUMNS-1)) ? '0 : col_r + COLW'(1);
      end
      tcw_pkg::CUR_NEWLINE: begin
        cursor_nxt = cursor_r + (CW'(COLUMNS) - CW'(col_r));
        col_nxt    = '0;
      end
      tcw_pkg::CUR_BACK: begin
        cursor_nxt = cursor_r - CW'(1);
        col_nxt    = (col_r == '0) ? COLW'(COLUMNS-1) : col_r - COLW'(1);
      end
      tcw_pkg::CUR_ROW_UP: begin
        cursor_nxt = cursor_r - CW'(COLUMNS);
      end
      tcw_pkg::CUR_HOME: begin
        cursor_nxt = '0;
        col_nxt    = '0;
      end
      default: begin
        cursor_nxt = cursor_r;
        col_nxt    = col_r;
      end
    endcase
  end

  // hold the position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      col_r    <= '0;
    end else begin
      cursor_r <= cursor_nxt;
      col_r    <= col_nxt;
    end
  end

  assign cursor = cursor_r;

endmodule
